// ----- src/fdsm_pkg.sv -----
// fdsm_pkg: command codes, result status codes and the controller/datapath
// command and status structs for the queue with second-minimum removal.
// no dependencies
`timescale 1ns / 1ps

package fdsm_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned OCC_W  = 5;

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_LIST   = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_PUSHED    = 3'd0,
      ST_FULL      = 3'd1,
      ST_POPPED    = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_SHORT     = 3'd4,
      ST_REMOVED   = 3'd5,
      ST_NO_SECOND = 3'd6,
      ST_LISTED    = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      VAL_ZERO = 2'd0,
      VAL_READ = 2'd1,
      VAL_HELD = 2'd2
   } val_sel_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic        load;          // capture the item, rewind the read index
      logic        rd_en;         // read entry at read index, advance index
      logic        idx_load_pos;  // read index to held position plus one
      logic        hold_head;     // held value from read data, position zero
      logic        scan_clr;      // clear min and second trackers
      logic        scan_upd;      // fold read data into the trackers
      logic        shift_wr;      // write read data one slot toward the head
      logic        push_wr;       // append captured value at the tail
      logic        cnt_dec;       // one entry fewer
      logic        emit;          // register one result
      status_type  status;
      val_sel_type val_sel;
      logic        last;
   } ctrl_type;

   // status from the datapath to the controller
   typedef struct packed {
      cmd_type cmd;
      logic    count_zero;
      logic    count_full;
      logic    count_lt2;
      logic    rd_at_end;   // every held entry has been read
      logic    dvalid;      // read data register holds a fresh entry
      logic    dat_last;    // that entry is the tail
      logic    sec_ok;      // a second distinct value was found
   } stat_type;

endpackage

// ----- src/fdsm_datapath.sv -----
// fdsm_datapath: entry memory, fill count, read/write indexes, min and second
// trackers and the result registers; driven by fdsm_controller.
// depends on fdsm_pkg
`timescale 1ns / 1ps

module fdsm_datapath #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [1:0]                         req_command,
   input  logic signed [fdsm_pkg::DATA_W-1:0] req_push_value,
   input  fdsm_pkg::ctrl_type                 ctrl,
   output fdsm_pkg::stat_type                 stat,
   output logic                               rsp_strobe,
   output logic [2:0]                         rsp_status,
   output logic signed [fdsm_pkg::DATA_W-1:0] rsp_item_value,
   output logic                               rsp_last_of_run,
   output logic [fdsm_pkg::OCC_W-1:0]         rsp_occupancy
);

   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW   = $clog2(DEPTH + 1);
   localparam int unsigned DW   = fdsm_pkg::DATA_W;
   localparam int unsigned OccW = fdsm_pkg::OCC_W;

   logic signed [DW-1:0] mem [DEPTH];

   fdsm_pkg::cmd_type    cmd_ff;
   logic signed [DW-1:0] value_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        rd_idx_ff, rd_idx_in;
   logic [AW-1:0]        wr_idx_ff;
   logic [AW-1:0]        dat_idx_ff;
   logic                 dvalid_ff;
   logic signed [DW-1:0] rdata_ff;

   logic                 min_ok_ff, min_ok_in;
   logic                 sec_ok_ff, sec_ok_in;
   logic signed [DW-1:0] mn_ff, mn_in;
   logic signed [DW-1:0] sec_ff, sec_in;
   logic [AW-1:0]        min_pos_ff, min_pos_in;
   logic [AW-1:0]        sec_pos_ff, sec_pos_in;

   logic                 rsp_strobe_ff;
   fdsm_pkg::status_type rsp_status_ff;
   logic signed [DW-1:0] rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff;
   logic [OccW-1:0]      rsp_occ_ff;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic signed [DW-1:0] wr_data;

   always_comb begin
      count_in = count_ff;
      if (ctrl.push_wr) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (ctrl.load) begin
         rd_idx_in = '0;
      end else if (ctrl.idx_load_pos) begin
         rd_idx_in = CW'(sec_pos_ff) + CW'(1);
      end else if (ctrl.rd_en) begin
         rd_idx_in = rd_idx_ff + CW'(1);
      end
   end

   // running min and second distinct min, first positions kept
   always_comb begin
      min_ok_in  = min_ok_ff;
      sec_ok_in  = sec_ok_ff;
      mn_in      = mn_ff;
      sec_in     = sec_ff;
      min_pos_in = min_pos_ff;
      sec_pos_in = sec_pos_ff;
      if (ctrl.scan_clr) begin
         min_ok_in = 1'b0;
         sec_ok_in = 1'b0;
      end else if (ctrl.hold_head) begin
         sec_in     = rdata_ff;
         sec_pos_in = '0;
      end else if (ctrl.scan_upd) begin
         if (!min_ok_ff || rdata_ff < mn_ff) begin
            if (min_ok_ff) begin
               sec_in     = mn_ff;
               sec_pos_in = min_pos_ff;
               sec_ok_in  = 1'b1;
            end
            mn_in      = rdata_ff;
            min_pos_in = dat_idx_ff;
            min_ok_in  = 1'b1;
         end else if (rdata_ff != mn_ff && (!sec_ok_ff || rdata_ff < sec_ff)) begin
            sec_in     = rdata_ff;
            sec_pos_in = dat_idx_ff;
            sec_ok_in  = 1'b1;
         end
      end
   end

   assign wr_en   = ctrl.push_wr | ctrl.shift_wr;
   assign wr_addr = ctrl.push_wr ? count_ff[AW-1:0] : wr_idx_ff;
   assign wr_data = ctrl.push_wr ? value_ff : rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rdata_ff   <= mem[rd_idx_ff[AW-1:0]];
         dat_idx_ff <= rd_idx_ff[AW-1:0];
      end
   end

   always_comb begin
      unique case (ctrl.val_sel)
         fdsm_pkg::VAL_READ: rsp_value_in = rdata_ff;
         fdsm_pkg::VAL_HELD: rsp_value_in = sec_ff;
         default:            rsp_value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         dvalid_ff     <= 1'b0;
         min_ok_ff     <= 1'b0;
         sec_ok_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rd_idx_ff     <= '0;
         wr_idx_ff     <= '0;
         cmd_ff        <= fdsm_pkg::CMD_PUSH;
      end else begin
         count_ff      <= count_in;
         dvalid_ff     <= ctrl.rd_en;
         min_ok_ff     <= min_ok_in;
         sec_ok_ff     <= sec_ok_in;
         rsp_strobe_ff <= ctrl.emit;
         rd_idx_ff     <= rd_idx_in;
         if (ctrl.load) begin
            cmd_ff <= fdsm_pkg::cmd_type'(req_command);
         end
         if (ctrl.idx_load_pos) begin
            wr_idx_ff <= sec_pos_ff;
         end else if (ctrl.shift_wr) begin
            wr_idx_ff <= wr_idx_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      mn_ff      <= mn_in;
      sec_ff     <= sec_in;
      min_pos_ff <= min_pos_in;
      sec_pos_ff <= sec_pos_in;
      if (ctrl.load) begin
         value_ff <= req_push_value;
      end
      if (ctrl.emit) begin
         rsp_status_ff <= ctrl.status;
         rsp_value_ff  <= rsp_value_in;
         rsp_last_ff   <= ctrl.last;
         rsp_occ_ff    <= OccW'(count_in);
      end
   end

   assign stat.cmd        = cmd_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.count_full = (count_ff >= CW'(DEPTH));
   assign stat.count_lt2  = (count_ff < CW'(2));
   assign stat.rd_at_end  = (rd_idx_ff == count_ff);
   assign stat.dvalid     = dvalid_ff;
   assign stat.dat_last   = ((CW'(dat_idx_ff) + CW'(1)) == count_ff);
   assign stat.sec_ok     = sec_ok_ff;

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_item_value  = rsp_value_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_occupancy   = rsp_occ_ff;

endmodule

// ----- src/fdsm_controller.sv -----
// fdsm_controller: state machine that sequences push, pop, list and
// second-minimum removal over the datapath.
// depends on fdsm_pkg
`timescale 1ns / 1ps

module fdsm_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  fdsm_pkg::stat_type stat,
   output fdsm_pkg::ctrl_type ctrl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_POP_CAP,
      S_LIST,
      S_SCAN,
      S_DECIDE,
      S_SHIFT_START,
      S_SHIFT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            ctrl.last = 1'b1;
            unique case (stat.cmd)
               fdsm_pkg::CMD_PUSH: begin
                  ctrl.emit = 1'b1;
                  if (stat.count_full) begin
                     ctrl.status = fdsm_pkg::ST_FULL;
                  end else begin
                     ctrl.push_wr = 1'b1;
                     ctrl.status  = fdsm_pkg::ST_PUSHED;
                  end
                  state_in = S_IDLE;
               end
               fdsm_pkg::CMD_POP: begin
                  if (stat.count_zero) begin
                     ctrl.emit   = 1'b1;
                     ctrl.status = fdsm_pkg::ST_EMPTY;
                     state_in    = S_IDLE;
                  end else begin
                     ctrl.rd_en = 1'b1;
                     state_in   = S_POP_CAP;
                  end
               end
               fdsm_pkg::CMD_LIST: begin
                  if (stat.count_zero) begin
                     ctrl.emit   = 1'b1;
                     ctrl.status = fdsm_pkg::ST_EMPTY;
                     state_in    = S_IDLE;
                  end else begin
                     state_in = S_LIST;
                  end
               end
               default: begin
                  if (stat.count_lt2) begin
                     ctrl.emit   = 1'b1;
                     ctrl.status = fdsm_pkg::ST_SHORT;
                     state_in    = S_IDLE;
                  end else begin
                     ctrl.scan_clr = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
            endcase
         end
         S_POP_CAP: begin
            ctrl.hold_head = 1'b1;
            state_in       = S_SHIFT_START;
         end
         S_LIST: begin
            ctrl.rd_en = !stat.rd_at_end;
            if (stat.dvalid) begin
               ctrl.emit    = 1'b1;
               ctrl.status  = fdsm_pkg::ST_LISTED;
               ctrl.val_sel = fdsm_pkg::VAL_READ;
               ctrl.last    = stat.dat_last;
               if (stat.dat_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SCAN: begin
            ctrl.rd_en    = !stat.rd_at_end;
            ctrl.scan_upd = stat.dvalid;
            if (stat.dvalid && stat.dat_last) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.sec_ok) begin
               state_in = S_SHIFT_START;
            end else begin
               ctrl.emit   = 1'b1;
               ctrl.status = fdsm_pkg::ST_NO_SECOND;
               ctrl.last   = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SHIFT_START: begin
            ctrl.idx_load_pos = 1'b1;
            state_in          = S_SHIFT;
         end
         S_SHIFT: begin
            ctrl.rd_en    = !stat.rd_at_end;
            ctrl.shift_wr = stat.dvalid;
            if (stat.rd_at_end && !stat.dvalid) begin
               ctrl.cnt_dec = 1'b1;
               ctrl.emit    = 1'b1;
               ctrl.val_sel = fdsm_pkg::VAL_HELD;
               ctrl.last    = 1'b1;
               ctrl.status  = (stat.cmd == fdsm_pkg::CMD_POP) ?
                              fdsm_pkg::ST_POPPED : fdsm_pkg::ST_REMOVED;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ----- src/fifo_delete_second_min.sv -----
// fifo_delete_second_min: top level of the bounded ordered queue with
// second-minimum removal; joins fdsm_controller and fdsm_datapath.
// depends on fdsm_pkg, fdsm_controller, fdsm_datapath
`timescale 1ns / 1ps

// a queue of up to DEPTH signed 32-bit entries, head at slot zero. an item is
// taken when start is high and busy is low; busy stays high until the last
// result of that item is on the rsp_ ports. every result shows for exactly one
// cycle with rsp_strobe high and cannot be held off, so the receiver must take
// it in that cycle. rsp_last_of_run marks the final result of an item and
// rsp_occupancy gives the entry count after the item (low 5 bits).
// pop reads the head and shifts the entries behind it toward the head;
// remove runs one scan pass plus a shift pass over the entries behind the
// removed one, longest when it is the head. push when full, pop or list when
// empty, remove on a short queue and remove with no second distinct value
// give a single status result. the passes are paced by the single read port
// of the entry memory: scan, list and the gap-closing shift each move one
// entry per cycle

module fifo_delete_second_min #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_command,
   input  logic signed [fdsm_pkg::DATA_W-1:0] req_push_value,
   output logic                               rsp_strobe,
   output logic [2:0]                         rsp_status,
   output logic signed [fdsm_pkg::DATA_W-1:0] rsp_item_value,
   output logic                               rsp_last_of_run,
   output logic [fdsm_pkg::OCC_W-1:0]         rsp_occupancy
);

   // command and status between the sequencer and the data side
   fdsm_pkg::ctrl_type ctrl;
   fdsm_pkg::stat_type stat;

   // sequencer: dispatches the item, runs scan, list and shift passes
   fdsm_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   // entry memory, trackers and the registered result
   fdsm_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_command),
      .req_push_value  (req_push_value),
      .ctrl            (ctrl),
      .stat            (stat),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_item_value  (rsp_item_value),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_occupancy   (rsp_occupancy)
   );

endmodule
